### design/dhtr_pkg.sv
// ----------------------------------------------------------------------------
// dhtr_pkg: shared definitions for the single-wire humidity sensor reader
// Register map, reset values, configuration bundle and stream word layout.
// ----------------------------------------------------------------------------
package dhtr_pkg;

    // Default number of data bits stored per reading.
    localparam int DATA_BITS_DEF = 40;

    // Number of received bytes presented on the result stream.
    localparam int OUT_BYTES = 5;

    // Configuration port geometry.
    localparam int APB_DW = 32;
    localparam int APB_AW = 5;

    // Register indexes (byte address is four times the index).
    localparam logic [2:0] REG_START_LOW    = 3'd0;
    localparam logic [2:0] REG_RELEASE_HIGH = 3'd1;
    localparam logic [2:0] REG_ONE_THRESH   = 3'd2;
    localparam logic [2:0] REG_TIMEOUT      = 3'd3;
    localparam logic [2:0] REG_EDGE_LIMIT   = 3'd4;

    // Register reset values.
    localparam logic [15:0] START_LOW_RST    = 16'd18000;
    localparam logic [7:0]  RELEASE_HIGH_RST = 8'd40;
    localparam logic [7:0]  ONE_THRESH_RST   = 8'd16;
    localparam logic [7:0]  TIMEOUT_RST      = 8'd255;
    localparam logic [6:0]  EDGE_LIMIT_RST   = 7'd85;

    // Input kind codes.
    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_START = 1'b1;

    // Result word width: 5 flags, 5 bytes, 6-bit count, padded to bytes.
    localparam int RES_BITS = 5 + 8 * OUT_BYTES + 6;
    localparam int RES_DW   = ((RES_BITS + 7) / 8) * 8;

    typedef struct packed {
        logic [15:0] start_low_ticks;
        logic [7:0]  release_high_ticks;
        logic [7:0]  one_threshold;
        logic [7:0]  timeout_ticks;
        logic [6:0]  edge_limit;
    } cfg_t;

endpackage

### design/dhtr_regs.sv
// ----------------------------------------------------------------------------
// dhtr_regs: configuration register file
// APB-style register bank holding the timing settings of the reader.
// ----------------------------------------------------------------------------
module dhtr_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dhtr_pkg::APB_AW-1:0]   paddr,
    input  logic [dhtr_pkg::APB_DW-1:0]   pwdata,
    output logic [dhtr_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    output dhtr_pkg::cfg_t                cfg
);

    dhtr_pkg::cfg_t cfg_reg;
    logic [2:0]     reg_index;
    logic           wr_en;

    assign pready    = 1'b1;
    assign reg_index = paddr[dhtr_pkg::APB_AW-1:2];
    assign wr_en     = psel && penable && pwrite;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_low_ticks    <= dhtr_pkg::START_LOW_RST;
            cfg_reg.release_high_ticks <= dhtr_pkg::RELEASE_HIGH_RST;
            cfg_reg.one_threshold      <= dhtr_pkg::ONE_THRESH_RST;
            cfg_reg.timeout_ticks      <= dhtr_pkg::TIMEOUT_RST;
            cfg_reg.edge_limit         <= dhtr_pkg::EDGE_LIMIT_RST;
        end else if (wr_en) begin
            case (reg_index)
                dhtr_pkg::REG_START_LOW:    cfg_reg.start_low_ticks    <= pwdata[15:0];
                dhtr_pkg::REG_RELEASE_HIGH: cfg_reg.release_high_ticks <= pwdata[7:0];
                dhtr_pkg::REG_ONE_THRESH:   cfg_reg.one_threshold      <= pwdata[7:0];
                dhtr_pkg::REG_TIMEOUT:      cfg_reg.timeout_ticks      <= pwdata[7:0];
                dhtr_pkg::REG_EDGE_LIMIT:   cfg_reg.edge_limit         <= pwdata[6:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_index)
            dhtr_pkg::REG_START_LOW:    prdata = {16'd0, cfg_reg.start_low_ticks};
            dhtr_pkg::REG_RELEASE_HIGH: prdata = {24'd0, cfg_reg.release_high_ticks};
            dhtr_pkg::REG_ONE_THRESH:   prdata = {24'd0, cfg_reg.one_threshold};
            dhtr_pkg::REG_TIMEOUT:      prdata = {24'd0, cfg_reg.timeout_ticks};
            dhtr_pkg::REG_EDGE_LIMIT:   prdata = {25'd0, cfg_reg.edge_limit};
            default:                    prdata = '0;
        endcase
    end

endmodule

### design/dht11_single_wire_reader_core.sv
// ----------------------------------------------------------------------------
// dht11_single_wire_reader_core: single-wire humidity sensor reader
// Drives the start request, times line pulses and collects the data bits.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Word contents
//  s_*       in         tuser: kind (0 tick, 1 start); tdata: line_level
//  m_*       out        one status word per input word (flags, bytes, count)
//  apb       in/out     five configuration registers at byte addresses 0..16
//
// Every input word produces exactly one result word. The whole update of the
// reader state is one short combinational step, so a word is accepted in
// every cycle while s_tready is high, and its result is registered. A
// two-entry output buffer (result register plus skid register) keeps
// accepting while a result waits; s_tready falls only when both entries are
// full. Reset is synchronous and active low.
module dht11_single_wire_reader_core #(
    parameter int DATA_BITS = dhtr_pkg::DATA_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Input stream.
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [0] line_level, [7:1] zero
    input  logic [0:0]                    s_tuser,   // [0] kind
    // Result stream.
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [0] drive_low, [1] drive_high, [2] busy_res, [3] done_res,
    // [4] timed_out, [12:5] humidity_int, [20:13] humidity_frac,
    // [28:21] temp_int, [36:29] temp_frac, [44:37] check_byte,
    // [50:45] bits_received, [55:51] zero
    output logic [dhtr_pkg::RES_DW-1:0]   m_tdata,
    // Configuration port.
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dhtr_pkg::APB_AW-1:0]   paddr,
    input  logic [dhtr_pkg::APB_DW-1:0]   pwdata,
    output logic [dhtr_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);

    // Stored bytes and bit counter width follow the data length.
    localparam int NBYTES = (DATA_BITS + 7) / 8;
    localparam int BIT_W  = $clog2(DATA_BITS + 1);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_LOW,
        PH_HIGH,
        PH_READ
    } phase_t;

    dhtr_pkg::cfg_t cfg;

    dhtr_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Reader state.
    phase_t            phase_reg, phase_next;
    logic [15:0]       timer_reg, timer_next;
    logic              prev_level_reg, prev_level_next;
    logic [7:0]        run_reg, run_next;
    logic [6:0]        edge_idx_reg, edge_idx_next;
    logic [BIT_W-1:0]  bit_idx_reg, bit_idx_next;
    logic [7:0]        data_reg  [NBYTES];
    logic [7:0]        data_next [NBYTES];
    logic              timeout_reg, timeout_next;
    logic              done_now;

    // Output buffer.
    logic                         out_valid_reg;
    logic [dhtr_pkg::RES_DW-1:0]  out_data_reg;
    logic                         skid_valid_reg;
    logic [dhtr_pkg::RES_DW-1:0]  skid_data_reg;

    logic s_take;
    logic m_take;
    logic kind;
    logic level;

    // Step arithmetic.
    logic [15:0] timer_inc;
    logic        low_end;
    logic        high_end;
    logic [7:0]  run_inc;
    logic [6:0]  edge_inc;
    logic        bit_slot;
    logic        bit_val;

    logic [7:0]                  out_byte [dhtr_pkg::OUT_BYTES];
    logic [dhtr_pkg::RES_DW-1:0] res_word;

    assign s_tready = !skid_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign s_take   = s_tvalid && s_tready;
    assign m_take   = out_valid_reg && m_tready;
    assign kind     = s_tuser[0];
    assign level    = s_tdata[0];

    assign timer_inc = timer_reg + 16'd1;
    // The low phase ends when the incremented timer plus one reaches the
    // setting, so a setting of zero behaves as one.
    assign low_end   = ({1'b0, timer_inc} + 17'd1) >= {1'b0, cfg.start_low_ticks};
    assign high_end  = timer_inc >= {8'd0, cfg.release_high_ticks};
    assign run_inc   = run_reg + 8'd1;
    assign edge_inc  = edge_idx_reg + 7'd1;
    // Data bits are taken on line transitions with an even index of at least 4, until storage is full.
    assign bit_slot  = (edge_idx_reg >= 7'd4) && !edge_idx_reg[0]
                       && (bit_idx_reg < BIT_W'(DATA_BITS));
    assign bit_val   = run_reg > cfg.one_threshold;

    always_comb begin
        phase_next      = phase_reg;
        timer_next      = timer_reg;
        prev_level_next = prev_level_reg;
        run_next        = run_reg;
        edge_idx_next   = edge_idx_reg;
        bit_idx_next    = bit_idx_reg;
        timeout_next    = timeout_reg;
        done_now        = 1'b0;
        for (int j = 0; j < NBYTES; j++) begin
            data_next[j] = data_reg[j];
        end

        if (kind == dhtr_pkg::KIND_START) begin
            // A start restarts the reading from scratch, even when busy.
            phase_next      = PH_LOW;
            timer_next      = '0;
            prev_level_next = 1'b1;
            run_next        = '0;
            edge_idx_next   = '0;
            bit_idx_next    = '0;
            timeout_next    = 1'b0;
            for (int j = 0; j < NBYTES; j++) begin
                data_next[j] = '0;
            end
        end else begin
            case (phase_reg)
                PH_LOW: begin
                    timer_next = timer_inc;
                    if (low_end) begin
                        timer_next = '0;
                        phase_next = (cfg.release_high_ticks == 8'd0) ? PH_READ : PH_HIGH;
                    end
                end
                PH_HIGH: begin
                    timer_next = timer_inc;
                    if (high_end) begin
                        timer_next = '0;
                        phase_next = PH_READ;
                    end
                end
                PH_READ: begin
                    if (level == prev_level_reg) begin
                        run_next = run_inc;
                        if (run_inc >= cfg.timeout_ticks) begin
                            timeout_next = 1'b1;
                            phase_next   = PH_IDLE;
                            done_now     = 1'b1;
                        end
                    end else begin
                        if (bit_slot) begin
                            for (int j = 0; j < NBYTES; j++) begin
                                if ((bit_idx_reg >> 3) == BIT_W'(j)) begin
                                    data_next[j] = {data_reg[j][6:0], bit_val};
                                end
                            end
                            bit_idx_next = bit_idx_reg + BIT_W'(1);
                        end
                        prev_level_next = level;
                        run_next        = '0;
                        edge_idx_next   = edge_inc;
                        if (edge_inc >= cfg.edge_limit) begin
                            phase_next = PH_IDLE;
                            done_now   = 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Bytes beyond the stored length read as zero.
    for (genvar k = 0; k < dhtr_pkg::OUT_BYTES; k++) begin : g_out_byte
        if (k < NBYTES) begin : g_stored
            assign out_byte[k] = data_next[k];
        end else begin : g_absent
            assign out_byte[k] = '0;
        end
    end

    assign res_word = dhtr_pkg::RES_DW'({
        6'(bit_idx_next),
        out_byte[4], out_byte[3], out_byte[2], out_byte[1], out_byte[0],
        timeout_next,
        done_now,
        phase_next != PH_IDLE,
        phase_next == PH_HIGH,
        phase_next == PH_LOW
    });

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            timer_reg      <= '0;
            prev_level_reg <= 1'b1;
            run_reg        <= '0;
            edge_idx_reg   <= '0;
            bit_idx_reg    <= '0;
            timeout_reg    <= 1'b0;
            for (int j = 0; j < NBYTES; j++) begin
                data_reg[j] <= '0;
            end
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (s_take) begin
                phase_reg      <= phase_next;
                timer_reg      <= timer_next;
                prev_level_reg <= prev_level_next;
                run_reg        <= run_next;
                edge_idx_reg   <= edge_idx_next;
                bit_idx_reg    <= bit_idx_next;
                timeout_reg    <= timeout_next;
                for (int j = 0; j < NBYTES; j++) begin
                    data_reg[j] <= data_next[j];
                end
            end

            if (skid_valid_reg) begin
                // Input is stalled; drain the skid entry into the output.
                if (m_take) begin
                    out_data_reg   <= skid_data_reg;
                    skid_valid_reg <= 1'b0;
                end
            end else if (s_take) begin
                if (!out_valid_reg || m_take) begin
                    out_data_reg  <= res_word;
                    out_valid_reg <= 1'b1;
                end else begin
                    skid_data_reg  <= res_word;
                    skid_valid_reg <= 1'b1;
                end
            end else if (m_take) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule
